// ===== rtl/cwt_pkg.sv =====
// Shared constants, types and codes of the calorimeter window trigger.
package cwt_pkg;

  localparam int MAP_COLS   = 48;
  localparam int MAP_ROWS   = 64;
  localparam int JET_SIDE   = 16;
  localparam int GAMMA_SIDE = 2;

  localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int SIDE_W    = $clog2(JET_SIDE + 1);
  localparam int COORD_W   = 9;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int AMP_W  = 12;
  localparam int CHG_W  = 16;
  localparam int CELL_W = 18;
  localparam int SUM_W  = 26;
  localparam int ACC_W  = CELL_W + 2 * SIDE_W;
  localparam int THR_W  = 31;

  localparam int NUM_CFG   = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int HALF_W    = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_CHARGE = 3'd2,
    CMD_JET    = 3'd3,
    CMD_GAMMA  = 3'd4
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_JET_OFF = 3'd4;

  localparam int THR_JET_HIGH   = 0;
  localparam int THR_GAMMA_HIGH = 1;
  localparam int THR_JET_LOW    = 2;
  localparam int THR_GAMMA_LOW  = 3;

  typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_regs_t;
  typedef logic [3:0][THR_W-1:0] thr_set_t;

endpackage

// ===== rtl/cwt_if.sv =====
// Command and result channels of the calorimeter window trigger.
interface cwt_cmd_if;
  logic                     valid;
  logic                     ready;
  logic [cwt_pkg::CMD_W-1:0] command;
  logic [cwt_pkg::POS_W-1:0] tower_col;
  logic [cwt_pkg::POS_W-1:0] tower_row;
  logic [cwt_pkg::AMP_W-1:0] amplitude;
  logic [cwt_pkg::CHG_W-1:0] charge_side_a;
  logic [cwt_pkg::CHG_W-1:0] charge_side_c;

  modport source(output valid, command, tower_col, tower_row, amplitude,
                 charge_side_a, charge_side_c, input ready);
  modport sink(input valid, command, tower_col, tower_row, amplitude,
               charge_side_a, charge_side_c, output ready);
endinterface

interface cwt_res_if;
  logic                     valid;
  logic                     ready;
  logic [cwt_pkg::SUM_W-1:0] window_sum;
  logic                     low_fired;
  logic                     high_fired;
  logic                     bad_position;

  modport source(output valid, window_sum, low_fired, high_fired, bad_position,
                 input ready);
  modport sink(input valid, window_sum, low_fired, high_fired, bad_position,
               output ready);
endinterface

// ===== rtl/cwt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/cwt_thr.sv =====
// Threshold latch: four thresholds from the charge sum over one shared multiplier.
module cwt_thr (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cwt_pkg::CHG_W:0]    charge_sum,
  input  cwt_pkg::cfg_regs_t         cfg,
  output cwt_pkg::thr_set_t          thr,
  output logic                       busy
);
  localparam int S_W    = cwt_pkg::CHG_W + 1;
  localparam int PROD_W = cwt_pkg::HALF_W + S_W;
  localparam int TSUM_W = cwt_pkg::HALF_W + 3;

  logic [1:0]                  k;
  logic [1:0]                  ph;
  logic [S_W-1:0]              s;
  logic [PROD_W-1:0]           p1;
  logic [PROD_W-1:0]           lo_part;
  logic [cwt_pkg::HALF_W-1:0]  term;
  logic [cwt_pkg::HALF_W-1:0]  mul_a;
  logic [PROD_W-1:0]           prod;
  logic [cwt_pkg::CFG_W-1:0]   ql;
  logic [cwt_pkg::CFG_W-1:0]   offs;
  logic [cwt_pkg::HALF_W-1:0]  konst;
  logic [TSUM_W-1:0]           tsum;
  logic [cwt_pkg::THR_W-1:0]   tsat;

  always_comb begin
    ql    = cfg[k];
    offs  = cfg[cwt_pkg::CFG_JET_OFF + {2'b00, k[0]}];
    konst = k[1] ? offs[cwt_pkg::HALF_W-1:0] : offs[cwt_pkg::CFG_W-1:cwt_pkg::HALF_W];
    case (ph)
      2'd0:    mul_a = ql[cwt_pkg::CFG_W-1:cwt_pkg::HALF_W];
      2'd1:    mul_a = p1[cwt_pkg::HALF_W-1:0];
      2'd2:    mul_a = cwt_pkg::HALF_W'(p1[PROD_W-1:cwt_pkg::HALF_W]);
      default: mul_a = ql[cwt_pkg::HALF_W-1:0];
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(s);
    // constant term plus linear term (L*S)>>16 plus quadratic term
    tsum = TSUM_W'(term) + TSUM_W'(prod[PROD_W-1:16]) + TSUM_W'(konst);
    tsat = (tsum > TSUM_W'({cwt_pkg::THR_W{1'b1}})) ? {cwt_pkg::THR_W{1'b1}}
                                                    : tsum[cwt_pkg::THR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
      ph   <= '0;
      thr  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      k    <= '0;
      ph   <= '0;
      s    <= charge_sum;
    end else if (busy) begin
      ph <= ph + 2'd1;
      case (ph)
        2'd0: p1 <= prod;
        2'd1: lo_part <= prod;
        // bits 63..32 of Q*S*S: upper part of the low product plus the high product
        2'd2: term <= cwt_pkg::HALF_W'(lo_part[PROD_W-1:cwt_pkg::HALF_W])
                      + prod[cwt_pkg::HALF_W-1:0];
        default: begin
          thr[k] <= tsat;
          k      <= k + 2'd1;
          if (k == 2'd3) begin
            busy <= 1'b0;
          end
        end
      endcase
    end
  end
endmodule

// ===== rtl/calorimeter_window_trigger.sv =====
// Top level: amplitude map in RAM, add/clear/evaluate sequencer and threshold latch.
//
//   port       dir  handshake        carries
//   cmd        in   valid/ready      command, tower_col, tower_row, amplitude, charges
//   res        out  valid/ready      window_sum, low_fired, high_fired, bad_position
//   cfg_*      in   cfg_we           cfg_index, cfg_data (64 bits)
//
// One item at a time. Jet and gamma windows are read cell by cell through the single map
// read port; set charges computes four thresholds, four multiplies each.
// Clear map sweeps all 3072 entries, one per cycle; the same sweep runs after reset,
// during which cmd.ready is low. A finished result waits in the output register while the
// next item is accepted; a new result is held back until that register is free.
module calorimeter_window_trigger (
  input  logic                             clk,
  input  logic                             rst,
  cwt_cmd_if.sink                          cmd,
  cwt_res_if.source                        res,
  input  logic                             cfg_we,
  input  logic [cwt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cwt_pkg::CFG_W-1:0]        cfg_data
);
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_CHG, S_EVAL, S_DONE
  } state_t;

  localparam int CW = cwt_pkg::COORD_W;
  localparam int AW = cwt_pkg::ADDR_W;
  localparam logic [cwt_pkg::CFG_IDX_W-1:0] CFG_IDX_LIMIT = cwt_pkg::CFG_IDX_W'(cwt_pkg::NUM_CFG);

  state_t                      st;
  cwt_pkg::cfg_regs_t          cfg_regs;
  cwt_pkg::thr_set_t           thr;
  logic                        thr_busy;
  logic                        thr_start;

  logic [AW-1:0]               clr_addr;
  logic                        clr_res;
  logic [cwt_pkg::POS_W-1:0]   col;
  logic [cwt_pkg::POS_W-1:0]   row;
  logic [cwt_pkg::AMP_W-1:0]   amp;
  logic                        is_jet;
  logic [cwt_pkg::SIDE_W-1:0]  side;
  logic [cwt_pkg::SIDE_W-1:0]  ci;
  logic [cwt_pkg::SIDE_W-1:0]  rj;
  logic                        issuing;
  logic                        rd_pend;
  logic [cwt_pkg::ACC_W-1:0]   acc;

  logic [cwt_pkg::SUM_W-1:0]   p_sum;
  logic                        p_low;
  logic                        p_high;
  logic                        p_bad;

  logic                        accept;
  logic [cwt_pkg::SIDE_W-1:0]  in_side;
  logic                        in_bad;
  logic                        in_map;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [cwt_pkg::CELL_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [cwt_pkg::CELL_W-1:0]  ram_rdata;
  logic [cwt_pkg::CELL_W:0]    cell_sum;
  logic [AW-1:0]               add_addr;
  logic [cwt_pkg::SUM_W-1:0]   sum_sat;
  logic                        thr_none;
  logic [cwt_pkg::THR_W-1:0]   thr_lo;
  logic [cwt_pkg::THR_W-1:0]   thr_hi;
  logic                        res_free;

  assign cmd.ready = (st == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign res_free  = !res.valid || res.ready;

  always_comb begin
    in_side = (cwt_pkg::cmd_t'(cmd.command) == cwt_pkg::CMD_JET)
              ? cwt_pkg::SIDE_W'(cwt_pkg::JET_SIDE) : cwt_pkg::SIDE_W'(cwt_pkg::GAMMA_SIDE);
    in_bad  = (CW'(cmd.tower_col) + CW'(in_side) > CW'(cwt_pkg::MAP_COLS))
           || (CW'(cmd.tower_row) + CW'(in_side) > CW'(cwt_pkg::MAP_ROWS));
    in_map  = (CW'(cmd.tower_col) < CW'(cwt_pkg::MAP_COLS))
           && (CW'(cmd.tower_row) < CW'(cwt_pkg::MAP_ROWS));
    thr_start = accept && (cwt_pkg::cmd_t'(cmd.command) == cwt_pkg::CMD_CHARGE);

    add_addr  = AW'(AW'(col) * AW'(cwt_pkg::MAP_ROWS) + AW'(row));
    ram_raddr = (st == S_EVAL)
                ? AW'((AW'(col) + AW'(ci)) * AW'(cwt_pkg::MAP_ROWS) + AW'(row) + AW'(rj))
                : add_addr;
    cell_sum  = {1'b0, ram_rdata} + (cwt_pkg::CELL_W + 1)'(amp);
    ram_we    = (st == S_CLEAR) || (st == S_ADD_WR);
    ram_waddr = (st == S_CLEAR) ? clr_addr : add_addr;
    ram_wdata = (st == S_CLEAR) ? '0
              : (cell_sum[cwt_pkg::CELL_W] ? {cwt_pkg::CELL_W{1'b1}}
                                            : cell_sum[cwt_pkg::CELL_W-1:0]);

    sum_sat  = (acc > cwt_pkg::ACC_W'({cwt_pkg::SUM_W{1'b1}})) ? {cwt_pkg::SUM_W{1'b1}}
                                                              : acc[cwt_pkg::SUM_W-1:0];
    thr_none = (thr[cwt_pkg::THR_JET_HIGH] == '0) && (thr[cwt_pkg::THR_JET_LOW] == '0);
    thr_lo   = is_jet ? thr[cwt_pkg::THR_JET_LOW]  : thr[cwt_pkg::THR_GAMMA_LOW];
    thr_hi   = is_jet ? thr[cwt_pkg::THR_JET_HIGH] : thr[cwt_pkg::THR_GAMMA_HIGH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_LIMIT)) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLEAR;
      clr_addr  <= '0;
      clr_res   <= 1'b0;
      issuing   <= 1'b0;
      rd_pend   <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      // load the output register when it is free, else clear valid once the result is taken
      if ((st == S_DONE) && res_free) begin
        res.valid        <= 1'b1;
        res.window_sum   <= p_sum;
        res.low_fired    <= p_low;
        res.high_fired   <= p_high;
        res.bad_position <= p_bad;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (st)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(cwt_pkg::MAP_DEPTH - 1)) begin
            st <= clr_res ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            col    <= cmd.tower_col;
            row    <= cmd.tower_row;
            amp    <= cmd.amplitude;
            is_jet <= (cwt_pkg::cmd_t'(cmd.command) == cwt_pkg::CMD_JET);
            side   <= in_side;
            p_sum  <= '0;
            p_low  <= 1'b0;
            p_high <= 1'b0;
            p_bad  <= 1'b0;
            case (cmd.command) inside
              cwt_pkg::CMD_CLEAR: begin
                clr_addr <= '0;
                clr_res  <= 1'b1;
                st       <= S_CLEAR;
              end
              cwt_pkg::CMD_ADD: st <= in_map ? S_ADD_RD : S_DONE;
              cwt_pkg::CMD_CHARGE: st <= S_CHG;
              cwt_pkg::CMD_JET, cwt_pkg::CMD_GAMMA: begin
                if (in_bad) begin
                  p_bad <= 1'b1;
                  st    <= S_DONE;
                end else begin
                  ci      <= '0;
                  rj      <= '0;
                  acc     <= '0;
                  issuing <= 1'b1;
                  st      <= S_EVAL;
                end
              end
              default: st <= S_DONE;
            endcase
          end
        end
        S_ADD_RD: st <= S_ADD_WR;
        S_ADD_WR: st <= S_DONE;
        S_CHG: begin
          if (!thr_busy) begin
            st <= S_DONE;
          end
        end
        S_EVAL: begin
          rd_pend <= issuing;
          if (rd_pend) begin
            acc <= acc + cwt_pkg::ACC_W'(ram_rdata);
          end
          if (issuing) begin
            // advance row first, then column
            if (rj == side - 1'b1) begin
              rj <= '0;
              ci <= ci + 1'b1;
              if (ci == side - 1'b1) begin
                issuing <= 1'b0;
              end
            end else begin
              rj <= rj + 1'b1;
            end
          end else if (!rd_pend) begin
            p_sum  <= sum_sat;
            p_low  <= !thr_none && (cwt_pkg::THR_W'(sum_sat) > thr_lo);
            p_high <= !thr_none && (cwt_pkg::THR_W'(sum_sat) > thr_hi);
            st     <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_free) begin
            clr_res <= 1'b0;
            st      <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  cwt_ram #(
    .WIDTH(cwt_pkg::CELL_W),
    .DEPTH(cwt_pkg::MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  cwt_thr u_thr (
    .clk       (clk),
    .rst       (rst),
    .start     (thr_start),
    .charge_sum({1'b0, cmd.charge_side_a} + {1'b0, cmd.charge_side_c}),
    .cfg       (cfg_regs),
    .thr       (thr),
    .busy      (thr_busy)
  );

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.bad_position |-> res.window_sum == '0 && !res.low_fired && !res.high_fired)
    else $error("bad position result carries a sum or fired flag");

  a_thr_idle: assert property (@(posedge clk) disable iff (rst)
    thr_start |-> !thr_busy)
    else $error("threshold latch restarted while busy");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    st == S_CLEAR |-> !cmd.ready && ram_we && ram_wdata == '0)
    else $error("map sweep not writing zeros or accepting items");

  a_eval_no_write: assert property (@(posedge clk) disable iff (rst)
    st == S_EVAL |-> !ram_we)
    else $error("map written during window evaluation");
endmodule
